[rtl/des_rf_pkg.sv]
package des_rf_pkg;

  // field widths
  localparam int unsigned HalfWidth = 32;
  localparam int unsigned KeyWidth  = 48;
  localparam int unsigned NumSboxes = 8;

  // expansion table E, DES bit numbers (1 = msb)
  localparam logic [5:0] E_TABLE [0:47] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  // permutation table P, DES bit numbers (1 = msb)
  localparam logic [5:0] P_TABLE [0:31] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  // s-boxes, indexed by row * 16 + column
  localparam logic [3:0] SBOX_TABLE [0:7][0:63] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  // expansion E: 32 -> 48 bits, pure wiring
  function automatic logic [KeyWidth-1:0] des_expand(input logic [HalfWidth-1:0] r);
    logic [KeyWidth-1:0] x;
    x = '0;
    for (int i = 0; i < KeyWidth; i++) begin
      x[KeyWidth-1-i] = r[HalfWidth - int'(E_TABLE[i])];
    end
    return x;
  endfunction

  // permutation P: 32 -> 32 bits, pure wiring
  function automatic logic [HalfWidth-1:0] des_permute(input logic [HalfWidth-1:0] s);
    logic [HalfWidth-1:0] y;
    y = '0;
    for (int i = 0; i < HalfWidth; i++) begin
      y[HalfWidth-1-i] = s[HalfWidth - int'(P_TABLE[i])];
    end
    return y;
  endfunction

endpackage

[rtl/des_round_function_top.sv]
// DES round function f: f_result = P(S(E(right_half) ^ round_key)).
//
// Input channel: a word (right_half_i, round_key_i) is taken at every
// rising edge where start is high and busy is low. busy is always low, so
// a new word may be issued in every cycle.
// Output channel: f_result_o is shown for exactly one cycle with valid_o
// high; the receiver must take it then, it cannot hold results off.
//
// Path: the accepted word goes through the input register, then the
// expansion/s-box/permutation logic, then the result register.
// Throughput: one word per cycle, set by the single registered pass
// through the s-box tables.
//
// Reset (rst_ni low, asynchronous) clears the valid flags; any word in
// flight is dropped and no strobe follows. The data registers are not reset.
module des_round_function_top
  import des_rf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic [HalfWidth-1:0] right_half_i,
  input  logic [KeyWidth-1:0]  round_key_i,
  output logic                 busy,
  output logic                 valid_o,
  output logic [HalfWidth-1:0] f_result_o
);

  logic                 in_valid_q, in_valid_d;
  logic [HalfWidth-1:0] half_q;
  logic [KeyWidth-1:0]  key_q;
  logic                 out_valid_q, out_valid_d;
  logic [HalfWidth-1:0] result_q, result_d;
  logic [KeyWidth-1:0]  mixed;
  logic [HalfWidth-1:0] sbits;
  logic                 accept;

  // never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign in_valid_d  = accept;
  assign out_valid_d = in_valid_q;

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      half_q <= right_half_i;
      key_q  <= round_key_i;
    end
  end

  // expansion and key mix
  assign mixed = des_expand(half_q) ^ key_q;

  des_rf_subst u_subst (
    .mixed_i (mixed),
    .sbits_o (sbits)
  );

  // final permutation
  assign result_d = des_permute(sbits);

  // result register
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign valid_o    = out_valid_q;
  assign f_result_o = result_q;

endmodule

[rtl/des_rf_subst.sv]
module des_rf_subst
  import des_rf_pkg::*;
(
  input  logic [KeyWidth-1:0]  mixed_i,
  output logic [HalfWidth-1:0] sbits_o
);

  // eight independent 6-to-4 lookups, group 1 at the msb end
  always_comb begin
    logic [5:0] grp;
    logic [5:0] idx;
    sbits_o = '0;
    for (int g = 0; g < NumSboxes; g++) begin
      grp = mixed_i[KeyWidth-1-6*g -: 6];
      // row from the outer bits, column from the inner four
      idx = {grp[5], grp[0], grp[4:1]};
      sbits_o[HalfWidth-1-4*g -: 4] = SBOX_TABLE[g][idx];
    end
  end

endmodule
